// ===== design/crcsg_pkg.sv =====
`default_nettype none

package crcsg_pkg;

   // remainder / generator width and degree field width
   localparam int GenBits = 31;
   localparam int DegW    = 5;

   // configuration port
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = GenBits;

   localparam logic [CsrIdxW-1:0] REG_GEN_LOW_COEFFS = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_GEN_DEGREE     = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_CHECK_MODE     = 2'd2;

   localparam logic [GenBits-1:0] GEN_LOW_COEFFS_RST = 31'd7;
   localparam logic [DegW-1:0]    GEN_DEGREE_RST     = 5'd8;
   localparam logic               CHECK_MODE_RST     = 1'b0;

   // job queue between front and back
   localparam int QueueDepth = 2;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = QPtrW + 1;

   typedef struct packed {
      logic [GenBits-1:0] poly;
      logic [DegW-1:0]    degree;
      logic               check_mode;
   } cfg_type;

   typedef struct packed {
      logic               check;
      logic               data_bit;
      logic               last;
      logic               ok;
      logic [GenBits-1:0] rem;
      logic [DegW-1:0]    degree;
   } job_type;

   // low d bits set
   function automatic logic [GenBits-1:0] deg_mask(input logic [DegW-1:0] d);
      logic [GenBits:0] m;
      m = ({{GenBits{1'b0}}, 1'b1} << d) - {{GenBits{1'b0}}, 1'b1};
      return m[GenBits-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/crcsg_req_if.sv =====
`default_nettype none

interface crcsg_req_if;
   logic valid;
   logic ready;
   logic in_bit;
   logic in_last;

   modport source (output valid, output in_bit, output in_last, input ready);
   modport sink   (input valid, input in_bit, input in_last, output ready);
endinterface

`default_nettype wire

// ===== design/crcsg_rsp_if.sv =====
`default_nettype none

interface crcsg_rsp_if;
   logic valid;
   logic ready;
   logic out_bit;
   logic out_last;
   logic check_ok;

   modport source (output valid, output out_bit, output out_last, output check_ok,
                   input ready);
   modport sink   (input valid, input out_bit, input out_last, input check_ok,
                   output ready);
endinterface

`default_nettype wire

// ===== design/crc_serial_generate_check_core.sv =====
`default_nettype none

// Bit-serial CRC generator and checker with a programmable generator
// G(x) = x^d + lower terms. Each request carries one bit, first bit first, and
// a last flag. In generate mode every bit is echoed on the response channel,
// and after the last bit the d remainder bits of M(x)*x^d mod G(x) follow,
// most significant first, the final one flagged last. In check mode the whole
// codeword is divided and a single response at the end of the frame reports
// check_ok = 1 when the remainder is zero. The remainder clears after every
// frame. Registers: index 0 gen_low_coeffs (bit k is the x^k coefficient),
// index 1 gen_degree (0..31, 0 means no remainder), index 2 check_mode.
// Write registers only between frames while no response is pending. Rate: one
// request per clock unless the queue is full; the front updates the division
// register and hands a job to a two-entry queue, and the back drains it. The
// queue backs up while the back sends a generate frame's d remainder bits.
module crc_serial_generate_check_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   crcsg_req_if.sink                              req,
   crcsg_rsp_if.source                            rsp,
   input  wire logic                              csr_wr_en,
   input  wire logic [crcsg_pkg::CsrIdxW-1:0]     csr_index,
   input  wire logic [crcsg_pkg::CsrDataW-1:0]    csr_wdata
);

   // configuration registers
   logic [crcsg_pkg::GenBits-1:0] gen_low_ff;
   logic [crcsg_pkg::DegW-1:0]    gen_degree_ff;
   logic                          check_mode_ff;
   crcsg_pkg::cfg_type            cfg;

   // front to queue to back
   logic               push, pop, q_full, q_empty;
   crcsg_pkg::job_type job, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_low_ff    <= crcsg_pkg::GEN_LOW_COEFFS_RST;
         gen_degree_ff <= crcsg_pkg::GEN_DEGREE_RST;
         check_mode_ff <= crcsg_pkg::CHECK_MODE_RST;
      end else if (csr_wr_en) begin
         // unknown index: write dropped
         unique case (csr_index)
            crcsg_pkg::REG_GEN_LOW_COEFFS: gen_low_ff <= csr_wdata;
            crcsg_pkg::REG_GEN_DEGREE:     gen_degree_ff <= csr_wdata[crcsg_pkg::DegW-1:0];
            crcsg_pkg::REG_CHECK_MODE:     check_mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // a 5-bit degree never exceeds 31, so it needs no saturation
   assign cfg.poly       = gen_low_ff;
   assign cfg.degree     = gen_degree_ff;
   assign cfg.check_mode = check_mode_ff;

   // front: accept a bit, step the division register, queue a job
   crcsg_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .cfg    (cfg),
      .q_full (q_full),
      .push   (push),
      .job    (job)
   );

   // short queue so front and back stall independently
   crcsg_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .job_in (job),
      .pop    (pop),
      .full   (q_full),
      .empty  (q_empty),
      .head   (head)
   );

   // back: echo / check result, then serialize the remainder
   crcsg_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (q_empty),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

// ===== design/crcsg_front.sv =====
`default_nettype none

module crcsg_front (
   input  wire logic              clock,
   input  wire logic              reset,
   crcsg_req_if.sink              req,
   input  wire crcsg_pkg::cfg_type cfg,
   input  wire logic              q_full,
   output logic                   push,
   output crcsg_pkg::job_type     job
);

   logic [crcsg_pkg::GenBits-1:0] rem_ff, rem_in;
   logic [crcsg_pkg::GenBits-1:0] mask, poly, cur, nxt_gen, nxt_chk;
   logic [crcsg_pkg::DegW-1:0]    top_idx;
   logic                          fb_top, accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   // check mode only yields a result on the final bit
   assign push      = accept && (!cfg.check_mode || req.in_last);

   always_comb begin
      mask    = crcsg_pkg::deg_mask(cfg.degree);
      poly    = cfg.poly & mask;
      cur     = rem_ff & mask;
      top_idx = cfg.degree - crcsg_pkg::DegW'(1);
      fb_top  = (cfg.degree != '0) ? cur[top_idx] : 1'b0;
      // augmented division for generate, plain division for check
      nxt_gen = ((cur << 1) & mask) ^ ({crcsg_pkg::GenBits{fb_top ^ req.in_bit}} & poly);
      nxt_chk = (((cur << 1) | {{(crcsg_pkg::GenBits-1){1'b0}}, req.in_bit}) & mask)
                ^ ({crcsg_pkg::GenBits{fb_top}} & poly);

      rem_in = rem_ff;
      if (accept) begin
         if (req.in_last) begin
            rem_in = '0;
         end else begin
            rem_in = cfg.check_mode ? nxt_chk : nxt_gen;
         end
      end

      job.check    = cfg.check_mode;
      job.data_bit = cfg.check_mode ? 1'b0 : req.in_bit;
      job.last     = req.in_last;
      job.ok       = cfg.check_mode && (nxt_chk == '0);
      job.rem      = nxt_gen;
      job.degree   = cfg.degree;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/crcsg_queue.sv =====
`default_nettype none

module crcsg_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire crcsg_pkg::job_type job_in,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output crcsg_pkg::job_type      head
);

   crcsg_pkg::job_type entry_ff [crcsg_pkg::QueueDepth];
   logic [crcsg_pkg::QPtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [crcsg_pkg::QCntW-1:0] count_ff, count_in;

   assign full  = (count_ff == crcsg_pkg::QCntW'(crcsg_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + crcsg_pkg::QPtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + crcsg_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + crcsg_pkg::QCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - crcsg_pkg::QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/crcsg_back.sv =====
`default_nettype none

module crcsg_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               empty,
   input  wire crcsg_pkg::job_type head,
   output logic                    pop,
   crcsg_rsp_if.source             rsp
);

   localparam logic ST_ECHO = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic                       state_ff, state_in;
   logic [crcsg_pkg::DegW-1:0] cnt_ff, cnt_in, bit_idx;
   logic                       valid_ff, valid_in;
   logic                       bit_ff, bit_in, last_ff, last_in, ok_ff, ok_in;
   logic                       advance, emit;

   assign advance      = !valid_ff || rsp.ready;
   assign rsp.valid    = valid_ff;
   assign rsp.out_bit  = bit_ff;
   assign rsp.out_last = last_ff;
   assign rsp.check_ok = ok_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      bit_in   = bit_ff;
      last_in  = last_ff;
      ok_in    = ok_ff;
      bit_idx  = cnt_ff - crcsg_pkg::DegW'(1);
      if (advance && !empty) begin
         emit = 1'b1;
         unique case (state_ff)
            ST_ECHO: begin
               bit_in  = head.data_bit;
               last_in = head.check || (head.last && (head.degree == '0));
               ok_in   = head.ok;
               if (!head.check && head.last && (head.degree != '0)) begin
                  state_in = ST_DUMP;
                  cnt_in   = head.degree;
               end else begin
                  pop = 1'b1;
               end
            end
            ST_DUMP: begin
               // remainder bits, most significant first
               bit_in  = head.rem[bit_idx];
               last_in = (cnt_ff == crcsg_pkg::DegW'(1));
               ok_in   = 1'b0;
               cnt_in  = bit_idx;
               if (cnt_ff == crcsg_pkg::DegW'(1)) begin
                  pop      = 1'b1;
                  state_in = ST_ECHO;
               end
            end
            default: begin
               state_in = ST_ECHO;
            end
         endcase
      end
      valid_in = advance ? emit : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ECHO;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      last_ff <= last_in;
      ok_ff   <= ok_in;
   end

endmodule

`default_nettype wire
